// ===== sv/sln50_pkg.sv =====
// Package: constants, command and status types for the segment length summary core.
`timescale 1ns / 1ps
package sln50_pkg;
    localparam int MAX_SEGMENTS = 1024;
    localparam int ADDR_W       = 10;
    localparam int CNT_W        = 11;
    localparam int POS_W        = 31;
    localparam int TOT_W        = 41;
    localparam int SPAN_W       = 48;
    localparam int MEAN_W       = 39;
    localparam int FRAC_W       = 17;
    localparam int FRACQ_W      = 16;
    localparam int DIVD_W       = 57;
    localparam int DIVS_W       = 48;
    localparam int DIVC_W       = 6;
    localparam int BIT_W        = 5;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

    typedef struct packed {
        logic store;
        logic clear;
        logic div_go;
        logic div_frac;
        logic scan_init;
        logic pass_begin;
        logic pass_run;
        logic bit_step;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic pass_done;
        logic bit_last;
    } dp_status_t;
endpackage

// ===== sv/sln50_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sln50_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/sln50_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sln50_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [sln50_pkg::DIVD_W-1:0]  dividend,
    input  logic [sln50_pkg::DIVS_W-1:0]  divisor,
    output logic [sln50_pkg::DIVD_W-1:0]  quotient,
    output logic                          done
);
    import sln50_pkg::*;

    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVC_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVD_W-1]};
        diff  = trial - {1'b0, divisor};
        if (!diff[DIVS_W])
        begin
            rem_next = diff[DIVS_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DIVS_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                cnt_reg <= DIVC_W'(DIVD_W);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIVC_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

// ===== sv/sln50_datapath.sv =====
// Datapath: length store, batch totals, shared divider and the N50 threshold search.
`timescale 1ns / 1ps
module sln50_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sln50_pkg::dp_cmd_t            cmd,
    output sln50_pkg::dp_status_t         status,
    input  logic [sln50_pkg::POS_W-1:0]   segment_start,
    input  logic [sln50_pkg::POS_W-1:0]   segment_end,
    input  logic                          cfg_valid,
    input  logic [sln50_pkg::SPAN_W-1:0]  cfg_data,
    output logic [sln50_pkg::CNT_W-1:0]   segment_count,
    output logic [sln50_pkg::MEAN_W-1:0]  mean_length_q8,
    output logic [sln50_pkg::FRAC_W-1:0]  covered_fraction_q16,
    output logic [sln50_pkg::POS_W-1:0]   n50_length,
    output logic                          store_overflow
);
    import sln50_pkg::*;

    logic [SPAN_W-1:0]  span_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [TOT_W-1:0]   total_reg;
    logic               ovf_reg;
    logic [MEAN_W-1:0]  mean_reg;
    logic [FRACQ_W-1:0] fracq_reg;
    logic [POS_W-1:0]   ans_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic [CNT_W-1:0]   rd_addr_reg;
    logic               rd_pend_reg;
    logic [TOT_W-1:0]   sum_reg;

    logic [POS_W-1:0]   seg_len;
    logic               room;
    logic               wr_en;
    logic               rd_en;
    logic [POS_W-1:0]   rd_data;
    logic [POS_W-1:0]   cand;
    logic               fits;
    logic [DIVD_W-1:0]  div_dividend;
    logic [DIVS_W-1:0]  div_divisor;
    logic [DIVD_W-1:0]  div_quo;
    logic               div_done;

    assign seg_len = (segment_end > segment_start) ? (segment_end - segment_start) : '0;
    assign room    = count_reg < CNT_W'(MAX_SEGMENTS);
    assign wr_en   = cmd.store && room;
    assign rd_en   = cmd.pass_run && (rd_addr_reg != count_reg);
    assign cand    = ans_reg | (POS_W'(1) << bit_reg);
    assign fits    = {sum_reg, 1'b0} <= {1'b0, total_reg};

    sln50_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (seg_len),
        .re    (rd_en),
        .raddr (rd_addr_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        if (cmd.div_frac)
        begin
            div_dividend = DIVD_W'({total_reg, 16'b0});
            div_divisor  = span_reg;
        end
        else
        begin
            div_dividend = DIVD_W'({total_reg, 8'b0});
            div_divisor  = DIVS_W'(count_reg);
        end
    end

    sln50_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg    <= SPAN_W'(1);
            count_reg   <= '0;
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                span_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
                total_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.store)
            begin
                if (room)
                begin
                    count_reg <= count_reg + 1'b1;
                    total_reg <= total_reg + TOT_W'(seg_len);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            rd_pend_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            if (cmd.div_frac)
            begin
                fracq_reg <= div_quo[FRACQ_W-1:0];
            end
            else
            begin
                mean_reg <= div_quo[MEAN_W-1:0];
            end
        end
        if (cmd.scan_init)
        begin
            ans_reg <= '0;
            bit_reg <= BIT_W'(POS_W - 1);
        end
        else if (cmd.bit_step)
        begin
            if (fits)
            begin
                ans_reg <= cand;
            end
            bit_reg <= bit_reg - 1'b1;
        end
        if (cmd.pass_begin)
        begin
            rd_addr_reg <= '0;
            sum_reg     <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
            end
            if (rd_pend_reg && (rd_data < cand))
            begin
                sum_reg <= sum_reg + TOT_W'(rd_data);
            end
        end
    end

    assign status.div_done  = div_done;
    assign status.pass_done = (rd_addr_reg == count_reg) && !rd_pend_reg;
    assign status.bit_last  = (bit_reg == '0);

    always_comb
    begin
        segment_count  = count_reg;
        store_overflow = ovf_reg;
        mean_length_q8 = (count_reg == '0) ? '0 : mean_reg;
        n50_length     = (total_reg == '0) ? '0 : ans_reg;
        if (total_reg == '0)
        begin
            covered_fraction_q16 = '0;
        end
        else if ({7'b0, total_reg} >= span_reg)
        begin
            covered_fraction_q16 = FRAC_ONE;
        end
        else
        begin
            covered_fraction_q16 = {1'b0, fracq_reg};
        end
    end
endmodule

// ===== sv/sln50_ctrl.sv =====
// Controller: loads the batch, then sequences the divisions and the N50 search.
`timescale 1ns / 1ps
module sln50_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   segment_present,
    input  logic                   last_in_batch,
    output logic                   busy,
    output logic                   result_valid,
    output sln50_pkg::dp_cmd_t     cmd,
    input  sln50_pkg::dp_status_t  status
);
    import sln50_pkg::*;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_MEAN  = 4'd1;
    localparam logic [3:0] S_MEANW = 4'd2;
    localparam logic [3:0] S_FRAC  = 4'd3;
    localparam logic [3:0] S_FRACW = 4'd4;
    localparam logic [3:0] S_INIT  = 4'd5;
    localparam logic [3:0] S_PBEG  = 4'd6;
    localparam logic [3:0] S_PASS  = 4'd7;
    localparam logic [3:0] S_BIT   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       accept;

    assign accept = start && (state_reg == S_LOAD);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.store = accept && segment_present;
                if (accept && last_in_batch)
                begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                cmd.div_go = 1'b1;
                state_next = S_MEANW;
            end
            S_MEANW:
            begin
                if (status.div_done)
                begin
                    state_next = S_FRAC;
                end
            end
            S_FRAC:
            begin
                cmd.div_go   = 1'b1;
                cmd.div_frac = 1'b1;
                state_next   = S_FRACW;
            end
            S_FRACW:
            begin
                cmd.div_frac = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_PBEG;
            end
            S_PBEG:
            begin
                cmd.pass_begin = 1'b1;
                state_next     = S_PASS;
            end
            S_PASS:
            begin
                cmd.pass_run = 1'b1;
                if (status.pass_done)
                begin
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                cmd.bit_step = 1'b1;
                state_next   = status.bit_last ? S_OUT : S_PBEG;
            end
            S_OUT:
            begin
                cmd.clear  = 1'b1;
                state_next = S_LOAD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy         = (state_reg != S_LOAD);
    assign result_valid = (state_reg == S_OUT);

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_in_batch) |=> busy)
        else $error("batch end did not start the summary");
    a_load_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_in_batch) |=> !busy)
        else $error("non-final beat left the load state");
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !busy && !result_valid)
        else $error("result not followed by idle");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == S_MEANW || state_reg == S_FRACW))
        else $error("divider finished outside a wait state");
endmodule

// ===== sv/segment_length_n50_summary_core.sv =====
// Top level: segment length summary core with mean, covered fraction and N50.
//
// channel   direction  handshake                    beat
// input     in         start & !busy                present, start, end, last
// config    in         cfg_valid & cfg_ready        total genome span (48 bits)
// result    out        result_valid, one cycle      count, mean, fraction, N50, overflow
//
// Segment beats are taken while busy is low. The beat marked last then holds
// busy through two runs of the shared restoring divider (mean, then covered
// fraction) and the N50 threshold search, one bit per pass over the n
// stored lengths through the single read port of the store, plus the states
// of sequencing. Reset clears the batch and sets the span to 1.
// The receiver cannot stall.
`timescale 1ns / 1ps
module segment_length_n50_summary_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          segment_present,
    input  logic [sln50_pkg::POS_W-1:0]   segment_start,
    input  logic [sln50_pkg::POS_W-1:0]   segment_end,
    input  logic                          last_in_batch,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sln50_pkg::SPAN_W-1:0]  cfg_data,
    output logic                          result_valid,
    output logic [sln50_pkg::CNT_W-1:0]   segment_count,
    output logic [sln50_pkg::MEAN_W-1:0]  mean_length_q8,
    output logic [sln50_pkg::FRAC_W-1:0]  covered_fraction_q16,
    output logic [sln50_pkg::POS_W-1:0]   n50_length,
    output logic                          store_overflow
);
    import sln50_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    sln50_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .segment_present (segment_present),
        .last_in_batch   (last_in_batch),
        .busy            (busy),
        .result_valid    (result_valid),
        .cmd             (cmd),
        .status          (status)
    );

    sln50_datapath u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .segment_start        (segment_start),
        .segment_end          (segment_end),
        .cfg_valid            (cfg_valid),
        .cfg_data             (cfg_data),
        .segment_count        (segment_count),
        .mean_length_q8       (mean_length_q8),
        .covered_fraction_q16 (covered_fraction_q16),
        .n50_length           (n50_length),
        .store_overflow       (store_overflow)
    );
endmodule

// ===== tb/sln50_checker.sv =====
// Checker: tracks batches and span, forms expected summaries and compares each result.
`timescale 1ns / 1ps
module sln50_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          segment_present,
    input  logic [sln50_pkg::POS_W-1:0]   segment_start,
    input  logic [sln50_pkg::POS_W-1:0]   segment_end,
    input  logic                          last_in_batch,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [sln50_pkg::SPAN_W-1:0]  cfg_data,
    input  logic                          result_valid,
    input  logic [sln50_pkg::CNT_W-1:0]   segment_count,
    input  logic [sln50_pkg::MEAN_W-1:0]  mean_length_q8,
    input  logic [sln50_pkg::FRAC_W-1:0]  covered_fraction_q16,
    input  logic [sln50_pkg::POS_W-1:0]   n50_length,
    input  logic                          store_overflow,
    output int                            fail_count,
    output int                            pending
);
    import sln50_pkg::*;

    typedef struct {
        logic [CNT_W-1:0]  count;
        logic [MEAN_W-1:0] mean;
        logic [FRAC_W-1:0] frac;
        logic [POS_W-1:0]  n50;
        logic              ovf;
    } summary_t;

    summary_t        summary_q[$];
    logic [POS_W-1:0] seg_lengths[$];
    logic [63:0]     span;
    logic [63:0]     batch_total;
    logic            batch_ovf;

    assign pending = summary_q.size();

    function automatic logic [POS_W-1:0] n50_of(logic [POS_W-1:0] lens[$], logic [63:0] tot);
        logic [POS_W-1:0] sorted[$];
        logic [63:0]      run;
        sorted = lens;
        sorted.sort();
        run = 64'd0;
        if (sorted.size() == 0 || tot == 64'd0)
            return '0;
        foreach (sorted[i])
        begin
            run += 64'(sorted[i]);
            if (2 * run > tot)
                return sorted[i];
        end
        return '0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        summary_t    s;
        summary_t    got;
        logic [63:0] n;
        logic [63:0] len;
        if (!rst_n)
        begin
            summary_q.delete();
            seg_lengths.delete();
            span        <= 64'd1;
            batch_total = 64'd0;
            batch_ovf   = 1'b0;
            fail_count  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                span <= 64'(cfg_data);
            if (start && !busy)
            begin
                if (segment_present)
                begin
                    len = (segment_end > segment_start) ?
                          64'(segment_end - segment_start) : 64'd0;
                    if (seg_lengths.size() < MAX_SEGMENTS)
                    begin
                        seg_lengths.push_back(len[POS_W-1:0]);
                        batch_total += len;
                    end
                    else
                        batch_ovf = 1'b1;
                end
                if (last_in_batch)
                begin
                    n = 64'(seg_lengths.size());
                    s.count = n[CNT_W-1:0];
                    s.ovf   = batch_ovf;
                    if (n == 64'd0)
                    begin
                        s.mean = '0;
                        s.frac = '0;
                        s.n50  = '0;
                    end
                    else
                    begin
                        s.mean = MEAN_W'((batch_total * 64'd256) / n);
                        if (batch_total == 64'd0)
                            s.frac = '0;
                        else if (batch_total >= span)
                            s.frac = FRAC_ONE;
                        else
                            s.frac = FRAC_W'((batch_total << 16) / span);
                        s.n50 = n50_of(seg_lengths, batch_total);
                    end
                    summary_q.push_back(s);
                    seg_lengths.delete();
                    batch_total = 64'd0;
                    batch_ovf   = 1'b0;
                end
            end
            if (result_valid)
            begin
                if (summary_q.size() == 0)
                begin
                    $display("%0t: result with none expected: count %0d", $time, segment_count);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    got = summary_q.pop_front();
                    if (got.count !== segment_count || got.mean !== mean_length_q8 ||
                        got.frac !== covered_fraction_q16 || got.n50 !== n50_length ||
                        got.ovf !== store_overflow)
                    begin
                        $display("%0t: mismatch exp cnt %0d mean %0d frac %0d n50 %0d ovf %0d",
                                 $time, got.count, got.mean, got.frac, got.n50, got.ovf);
                        $display("%0t:          got cnt %0d mean %0d frac %0d n50 %0d ovf %0d",
                                 $time, segment_count, mean_length_q8, covered_fraction_q16,
                                 n50_length, store_overflow);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb_segment_length_n50_summary_core.sv =====
// Testbench top: drives segment batches and span writes, gives the verdict.
`timescale 1ns / 1ps
module tb_segment_length_n50_summary_core;
    import sln50_pkg::*;

    localparam int STALL_LIMIT = 200000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              segment_present;
    logic [POS_W-1:0]  segment_start;
    logic [POS_W-1:0]  segment_end;
    logic              last_in_batch;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SPAN_W-1:0] cfg_data;
    logic              result_valid;
    logic [CNT_W-1:0]  segment_count;
    logic [MEAN_W-1:0] mean_length_q8;
    logic [FRAC_W-1:0] covered_fraction_q16;
    logic [POS_W-1:0]  n50_length;
    logic              store_overflow;
    int                fail_count;
    int                pending;
    int                quiet_cycles = 0;
    int                burst_left;
    int                items_sent;

    segment_length_n50_summary_core dut (.*);

    sln50_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_beat(logic p, logic [POS_W-1:0] s, logic [POS_W-1:0] e, logic l);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        start           <= 1'b1;
        segment_present <= p;
        segment_start   <= s;
        segment_end     <= e;
        last_in_batch   <= l;
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent++;
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_span(logic [SPAN_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [POS_W-1:0] rand_pos(int mode);
        case (mode)
            0: return POS_W'($urandom_range(0, 1000));
            1: return POS_W'($urandom);
            default: return POS_W'({$urandom} & {POS_W{1'b1}});
        endcase
    endfunction

    task automatic random_batch(int n, int mode);
        logic [POS_W-1:0] s;
        logic [POS_W-1:0] e;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_beat(1'b0, rand_pos(1), rand_pos(1), 1'b0);
            s = rand_pos(mode);
            e = ($urandom_range(0, 7) == 0) ? rand_pos(mode) : s + rand_pos(0);
            if (e < s && $urandom_range(0, 1)) e = s;
            send_beat(1'b1, s, e, i == n - 1);
        end
        if (n == 0)
            send_beat(1'b0, rand_pos(1), rand_pos(1), 1'b1);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        segment_present = 1'b0;
        segment_start   = '0;
        segment_end     = '0;
        last_in_batch   = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        burst_left      = 0;
        items_sent      = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset span of 1
        send_beat(1'b0, '0, '0, 1'b1);
        send_beat(1'b1, 31'd10, 31'd15, 1'b1);
        send_beat(1'b1, 31'd20, 31'd5, 1'b0);
        send_beat(1'b1, 31'd7, 31'd7, 1'b1);
        send_beat(1'b0, 31'd3, 31'd9, 1'b0);
        send_beat(1'b1, '0, '1, 1'b0);
        send_beat(1'b1, '1, '0, 1'b0);
        send_beat(1'b1, '0, '1, 1'b1);
        write_span('1);
        send_beat(1'b1, 31'd0, 31'd1, 1'b0);
        send_beat(1'b1, 31'd0, 31'd1, 1'b0);
        send_beat(1'b1, 31'd0, 31'd100, 1'b0);
        send_beat(1'b0, '1, '1, 1'b1);
        send_beat(1'b1, '0, '1, 1'b0);
        send_beat(1'b1, '0, '1, 1'b1);
        write_span('0);
        send_beat(1'b1, 31'd5, 31'd6, 1'b1);
        send_beat(1'b1, 31'd6, 31'd5, 1'b1);
        write_span(48'd1000);
        send_beat(1'b1, 31'd0, 31'd300, 1'b0);
        send_beat(1'b1, 31'd100, 31'd200, 1'b1);

        // store overflow: past capacity, count ends at capacity
        random_batch(MAX_SEGMENTS + 2, 0);
        write_span(48'd500000);

        while (items_sent < 1400)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: write_span('1);
                    1: write_span('0);
                    2: write_span(48'd1);
                    3: write_span(SPAN_W'($urandom_range(1, 100000)));
                    default: write_span(SPAN_W'({$urandom, $urandom}));
                endcase
            end
            random_batch($urandom_range(0, 4) == 0 ? $urandom_range(0, 2)
                                                   : $urandom_range(3, 30),
                         $urandom_range(0, 2));
        end

        settle();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
